// ----- hw/rtl/vmnf_pkg.sv -----
// vmnf_pkg: shared types and constants of the vertex mask neighborhood filter
// no dependencies; imported by the controller, the datapath and the checker

package vmnf_pkg;

  localparam int MASK_W  = 16;
  localparam int SUM_W   = 22;
  localparam int DVD_W   = 23;
  localparam int DIVR_W  = 7;
  localparam int STEPS   = DVD_W;
  localparam int STEP_W  = $clog2(STEPS);

  localparam logic [MASK_W-1:0] MASK_ONE     = 16'd32768;
  localparam logic [MASK_W-1:0] MASK_HALF    = 16'd16384;
  localparam logic [MASK_W-1:0] SHARPEN_STEP = 16'd1638;

  localparam logic [2:0] MODE_SMOOTH  = 3'd0;
  localparam logic [2:0] MODE_SHARPEN = 3'd1;
  localparam logic [2:0] MODE_GROW    = 3'd2;
  localparam logic [2:0] MODE_SHRINK  = 3'd3;
  localparam logic [2:0] MODE_CON_INC = 3'd4;
  localparam logic [2:0] MODE_CON_DEC = 3'd5;

  typedef enum logic [1:0] {
    ST_ACC,
    ST_LOAD,
    ST_DIV,
    ST_FIN
  } ctrl_state_t;

  typedef struct packed {
    logic accept;
    logic snap;
    logic load;
    logic step;
    logic out_load;
  } ctrl_cmd_t;

endpackage

// ----- hw/rtl/vmnf_ctrl.sv -----
// vmnf_ctrl: sequencer of the filter (request intake, divider steps, result hand-off)
// depends on vmnf_pkg; drives the datapath through ctrl_cmd_t

module vmnf_ctrl
  import vmnf_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_last_neighbor,
  output logic      in_stall,
  output logic      out_valid,
  input  logic      out_stall,
  output ctrl_cmd_t cmd
);

  ctrl_state_t       state_r, state_nxt;
  logic [STEP_W-1:0] step_cnt_r, step_cnt_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              last_step;

  assign last_step = (step_cnt_r == STEP_W'(STEPS - 1));

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_ACC: begin
        if (in_valid && in_last_neighbor) state_nxt = ST_LOAD;
      end
      ST_LOAD: state_nxt = ST_DIV;
      ST_DIV: begin
        if (last_step) state_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (!out_valid_r || !out_stall) state_nxt = ST_ACC;
      end
      default: state_nxt = ST_ACC;
    endcase
  end

  always_comb begin
    cmd          = '0;
    in_stall     = 1'b1;
    step_cnt_nxt = '0;
    case (state_r)
      ST_ACC: begin
        in_stall   = 1'b0;
        cmd.accept = in_valid;
        cmd.snap   = in_valid && in_last_neighbor;
      end
      ST_LOAD: cmd.load = 1'b1;
      ST_DIV: begin
        cmd.step     = 1'b1;
        step_cnt_nxt = last_step ? '0 : step_cnt_r + STEP_W'(1);
      end
      ST_FIN: cmd.out_load = !out_valid_r || !out_stall;
      default: cmd = '0;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;
    if (cmd.out_load) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_ACC;
      step_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_cnt_r  <= step_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// ----- hw/rtl/vmnf_datapath.sv -----
// vmnf_datapath: mode register, neighbor accumulators, shared restoring divider, result logic
// depends on vmnf_pkg; sequenced by vmnf_ctrl

module vmnf_datapath
  import vmnf_pkg::*;
#(
  parameter int MAX_NEIGHBORS = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic [2:0]        cfg_wr_data,
  input  logic [MASK_W-1:0] in_own_mask,
  input  logic [MASK_W-1:0] in_neighbor_mask,
  input  logic              in_has_neighbor,
  input  ctrl_cmd_t         cmd,
  output logic [MASK_W-1:0] out_filtered_mask
);

  localparam int CNT_W = $clog2(MAX_NEIGHBORS + 1);

  logic [2:0]        mode_r;
  logic [SUM_W-1:0]  sum_r, sum_nxt, sum_upd, sum_s_r;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt, cnt_upd, cnt_s_r;
  logic [MASK_W-1:0] max_r, max_nxt, max_upd, max_s_r;
  logic [MASK_W-1:0] min_r, min_nxt, min_upd, min_s_r;
  logic [MASK_W-1:0] own_s_r;
  logic              take;

  logic [DVD_W-1:0]  q_r, q_nxt;
  logic [DIVR_W:0]   rem_r, rem_nxt, rem_sh;
  logic [DIVR_W-1:0] div_r, div_nxt;
  logic              ge;
  logic [19:0]       own10;

  logic signed [25:0] own_x, q_x, diff, half, base, res;
  logic [MASK_W-1:0]  mask_out_r;

  function automatic logic [MASK_W-1:0] limit_mask(input logic signed [25:0] v);
    logic [MASK_W-1:0] c;
    if (v < 0) c = '0;
    else if (v > $signed({10'b0, MASK_ONE})) c = MASK_ONE;
    else c = v[MASK_W-1:0];
    return c;
  endfunction

  // accumulation including the current request
  always_comb begin
    take    = in_has_neighbor && (cnt_r < CNT_W'(MAX_NEIGHBORS));
    sum_upd = sum_r;
    cnt_upd = cnt_r;
    max_upd = max_r;
    min_upd = min_r;
    if (take) begin
      sum_upd = sum_r + SUM_W'(in_neighbor_mask);
      cnt_upd = cnt_r + CNT_W'(1);
      if (in_neighbor_mask > max_r) max_upd = in_neighbor_mask;
      if (in_neighbor_mask < min_r) min_upd = in_neighbor_mask;
    end
    sum_nxt = sum_r;
    cnt_nxt = cnt_r;
    max_nxt = max_r;
    min_nxt = min_r;
    if (cmd.snap) begin
      sum_nxt = '0;
      cnt_nxt = '0;
      max_nxt = '0;
      min_nxt = MASK_ONE;
    end else if (cmd.accept) begin
      sum_nxt = sum_upd;
      cnt_nxt = cnt_upd;
      max_nxt = max_upd;
      min_nxt = min_upd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_SMOOTH;
      sum_r  <= '0;
      cnt_r  <= '0;
      max_r  <= '0;
      min_r  <= MASK_ONE;
    end else begin
      if (cfg_wr_en) mode_r <= cfg_wr_data;
      sum_r <= sum_nxt;
      cnt_r <= cnt_nxt;
      max_r <= max_nxt;
      min_r <= min_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.snap) begin
      own_s_r <= in_own_mask;
      sum_s_r <= sum_upd;
      cnt_s_r <= cnt_upd;
      max_s_r <= max_upd;
      min_s_r <= min_upd;
    end
  end

  // divider operands per mode, then one quotient bit per step
  always_comb begin
    own10   = 20'(own_s_r) * 20'd10;
    rem_sh  = {rem_r[DIVR_W-1:0], q_r[DVD_W-1]};
    ge      = (rem_sh >= {1'b0, div_r});
    q_nxt   = q_r;
    rem_nxt = rem_r;
    div_nxt = div_r;
    if (cmd.load) begin
      rem_nxt = '0;
      case (mode_r)
        MODE_SMOOTH, MODE_SHARPEN: begin
          if (cnt_s_r == '0) begin
            q_nxt   = DVD_W'(own_s_r);
            div_nxt = DIVR_W'(1);
          end else begin
            q_nxt   = DVD_W'(sum_s_r) + DVD_W'(cnt_s_r >> 1);
            div_nxt = DIVR_W'(cnt_s_r);
          end
        end
        MODE_CON_INC: begin
          q_nxt   = (own10 <= 20'd16384) ? '0 : DVD_W'(own10 - 20'd16380);
          div_nxt = DIVR_W'(9);
        end
        MODE_CON_DEC: begin
          q_nxt   = DVD_W'(own_s_r) * DVD_W'(110) + DVD_W'(180274);
          div_nxt = DIVR_W'(100);
        end
        default: begin
          q_nxt   = '0;
          div_nxt = DIVR_W'(1);
        end
      endcase
    end else if (cmd.step) begin
      rem_nxt = ge ? rem_sh - {1'b0, div_r} : rem_sh;
      q_nxt   = {q_r[DVD_W-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    div_r <= div_nxt;
  end

  // final result
  always_comb begin
    own_x = $signed({10'b0, own_s_r});
    q_x   = $signed({3'b0, q_r});
    diff  = q_x - own_x;
    half  = $signed(diff + 26'(diff[25])) >>> 1;
    base  = (own_s_r > MASK_HALF) ? own_x + 26'(SHARPEN_STEP) : own_x - 26'(SHARPEN_STEP);
    case (mode_r)
      MODE_SMOOTH:  res = q_x;
      MODE_SHARPEN: res = base + half;
      MODE_GROW:    res = $signed({10'b0, max_s_r});
      MODE_SHRINK:  res = $signed({10'b0, min_s_r});
      MODE_CON_INC: res = q_x;
      MODE_CON_DEC: res = q_x;
      default:      res = own_x;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) mask_out_r <= limit_mask(res);
  end

  assign out_filtered_mask = mask_out_r;

endmodule

// ----- hw/rtl/vertex_mask_neighborhood_filter.sv -----
// Vertex mask neighborhood filter. Each request carries a vertex's own mask and one neighbor
// mask (Q1.15, 32768 is 1.0); requests that are not marked last are taken one per cycle and
// only accumulate sum, count, maximum and minimum of up to MAX_NEIGHBORS neighbors. The
// request marked last closes the vertex: the block then stalls its input while it sets up the
// divider operands, runs the bit-serial restoring divider that forms the mean and the contrast
// maps, and registers the result. A finished result waits in the output register while the
// next vertex streams in; if it is still held by out_stall when the next vertex is done,
// the input stays stalled until it is taken. The filter mode (mode_r) is written through
// cfg_wr_en / cfg_wr_data.

module vertex_mask_neighborhood_filter
  import vmnf_pkg::*;
#(
  parameter int MAX_NEIGHBORS = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic [2:0]        cfg_wr_data,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [MASK_W-1:0] in_own_mask,
  input  logic [MASK_W-1:0] in_neighbor_mask,
  input  logic              in_has_neighbor,
  input  logic              in_last_neighbor,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [MASK_W-1:0] out_filtered_mask
);

  ctrl_cmd_t cmd;

  vmnf_ctrl u_ctrl (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_last_neighbor (in_last_neighbor),
    .in_stall         (in_stall),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .cmd              (cmd)
  );

  vmnf_datapath #(
    .MAX_NEIGHBORS (MAX_NEIGHBORS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .in_own_mask       (in_own_mask),
    .in_neighbor_mask  (in_neighbor_mask),
    .in_has_neighbor   (in_has_neighbor),
    .cmd               (cmd),
    .out_filtered_mask (out_filtered_mask)
  );

endmodule

// ----- hw/rtl/vmnf_checker.sv -----
// vmnf_assertions: port-level assertions of the filter, bound to the top level
// depends on vmnf_pkg and vertex_mask_neighborhood_filter

module vmnf_assertions
  import vmnf_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input logic              in_last_neighbor,
  input logic              out_valid,
  input logic              out_stall,
  input logic [MASK_W-1:0] out_filtered_mask
);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result shown right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_filtered_mask))
    else $error("stalled result changed");

  a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_filtered_mask <= MASK_ONE)
    else $error("result above 1.0");

  a_busy_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_last_neighbor |=> in_stall)
    else $error("input open right after last request");

  a_result_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared without a finished vertex");

endmodule

bind vertex_mask_neighborhood_filter vmnf_assertions u_vmnf_assertions (.*);
